### rtl/csm_pkg.sv
package csm_pkg;

    // Payload and register geometry.
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int KEY_BYTES = 32;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    // ASCII bounds for the upper-to-lower fold.
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

    // Register map, one register every eight bytes.
    typedef enum logic [2:0] {
        REG_LENGTH = 3'd0,
        REG_WORD0  = 3'd1,
        REG_WORD1  = 3'd2,
        REG_WORD2  = 3'd3,
        REG_WORD3  = 3'd4
    } csm_reg_t;

    // A text byte matches a keyword byte directly or after folding A-Z to lower case.
    // The keyword byte is never folded.
    function automatic logic byte_match(input logic [BYTE_W-1:0] text_b,
                                        input logic [BYTE_W-1:0] key_b);
        logic [BYTE_W-1:0] folded;
        folded = text_b;
        if (text_b >= CHAR_UPPER_A && text_b <= CHAR_UPPER_Z)
        begin
            folded = text_b + CASE_OFFSET;
        end
        return (text_b == key_b) || (folded == key_b);
    endfunction

endpackage

### rtl/csm_in_if.sv
interface csm_in_if;
    logic                        valid;
    logic                        ready;
    logic [csm_pkg::BYTE_W-1:0]  text_byte;
    logic                        has_byte;
    logic                        is_last;

    modport source (output valid, output text_byte, output has_byte, output is_last,
                    input ready);
    modport sink   (input valid, input text_byte, input has_byte, input is_last,
                    output ready);
endinterface

### rtl/csm_out_if.sv
interface csm_out_if;
    logic valid;
    logic ready;
    logic contains;

    modport source (output valid, output contains, input ready);
    modport sink   (input valid, input contains, output ready);
endinterface

### rtl/case_insensitive_substring_match.sv
// A transaction marked is_last is registered in the input stage and processed from there into the
// result register, where its contains result is held until it is taken.
// Throughput: one text byte per cycle while the input side does not stall.
// The input side stalls only when an end-of-text item waits for a full result register.
// Reset (rst_n low, asynchronous) clears the match vector, the found flag, all pipeline
// valids and every configuration register to zero.
module case_insensitive_substring_match #(
    parameter int MAX_KEYWORD = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csm_pkg::ADDR_W-1:0]   paddr,
    input  logic [csm_pkg::DATA_W-1:0]   pwdata,
    output logic [csm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    csm_in_if.sink                       in_ch,
    csm_out_if.source                    out_ch
);

    localparam int SLOTS = (MAX_KEYWORD < csm_pkg::KEY_BYTES) ? MAX_KEYWORD
                                                              : csm_pkg::KEY_BYTES;
    localparam logic [csm_pkg::LEN_W-1:0] SLOTS_LEN = csm_pkg::LEN_W'(SLOTS);

    // Configuration registers.
    logic [csm_pkg::LEN_W-1:0]                            key_len_reg;
    logic [csm_pkg::NUM_WORDS-1:0][csm_pkg::WORD_W-1:0]   key_word_reg;

    // Input stage.
    logic                        s1_valid_reg;
    logic [csm_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                        s1_has_reg;
    logic                        s1_last_reg;

    // Match state and result register.
    logic [SLOTS-1:0]            pm_reg;
    logic [SLOTS-1:0]            pm_next;
    logic                        found_reg;
    logic                        found_next;
    logic                        out_valid_reg;
    logic                        out_contains_reg;

    logic                        wr_en;
    csm_pkg::csm_reg_t           reg_sel;
    logic [csm_pkg::LEN_W-1:0]   len_act;
    logic [SLOTS-1:0]            hits;
    logic                        top_hit;
    logic                        update;
    logic                        advance;
    logic                        process;

    // APB decode: one register every eight bytes.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = csm_pkg::csm_reg_t'(paddr[csm_pkg::ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= '0;
            key_word_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                csm_pkg::REG_LENGTH: key_len_reg     <= pwdata[csm_pkg::LEN_W-1:0];
                csm_pkg::REG_WORD0:  key_word_reg[0] <= pwdata;
                csm_pkg::REG_WORD1:  key_word_reg[1] <= pwdata;
                csm_pkg::REG_WORD2:  key_word_reg[2] <= pwdata;
                csm_pkg::REG_WORD3:  key_word_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_sel)
            csm_pkg::REG_LENGTH: prdata = csm_pkg::DATA_W'(key_len_reg);
            csm_pkg::REG_WORD0:  prdata = key_word_reg[0];
            csm_pkg::REG_WORD1:  prdata = key_word_reg[1];
            csm_pkg::REG_WORD2:  prdata = key_word_reg[2];
            csm_pkg::REG_WORD3:  prdata = key_word_reg[3];
            default:             prdata = '0;
        endcase
    end

    // The input stage moves on unless it holds an end of text and the result is still unread.
    assign advance     = !s1_last_reg || !out_valid_reg || out_ch.ready;
    assign process     = s1_valid_reg && advance;
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg <= in_ch.text_byte;
            s1_has_reg  <= in_ch.has_byte;
            s1_last_reg <= in_ch.is_last;
        end
    end

    // Keyword length in use, saturated to the number of slots.
    assign len_act = (key_len_reg > SLOTS_LEN) ? SLOTS_LEN : key_len_reg;

    // Parallel byte compare against every active keyword position.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hits[i] = (csm_pkg::LEN_W'(i) < len_act)
                && csm_pkg::byte_match(s1_byte_reg,
                                       key_word_reg[i / 8][(i % 8) * 8 +: 8]);
        end
    end

    // Shift-and update and full-match detect at the last active position.
    assign update  = s1_has_reg && (len_act != '0);
    assign pm_next = update ? (((pm_reg << 1) | SLOTS'(1)) & hits) : pm_reg;

    always_comb
    begin
        top_hit = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (csm_pkg::LEN_W'(i + 1) == len_act)
            begin
                top_hit = pm_next[i];
            end
        end
    end

    assign found_next = found_reg || (update && top_hit);

    // Match state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg           <= '0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_contains_reg <= 1'b0;
        end
        else
        begin
            if (process && s1_last_reg)
            begin
                pm_reg           <= '0;
                found_reg        <= 1'b0;
                out_valid_reg    <= 1'b1;
                out_contains_reg <= (len_act == '0) || found_next;
            end
            else
            begin
                if (process)
                begin
                    pm_reg    <= pm_next;
                    found_reg <= found_next;
                end
                if (out_ch.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.contains = out_contains_reg;

endmodule

### rtl/csm_checker.sv
module csm_checker (
    input logic clk,
    input logic rst_n,
    input logic pready,
    input logic in_valid,
    input logic in_ready,
    input logic in_is_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_contains
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_contains))
    else $error("contains changed while the result was stalled");

    // The configuration port never inserts wait states.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

    // A result register being drained means the input side is never blocked.
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
    else $error("input stalled while the result side was ready");

    // A fresh result follows an accepted end-of-text transaction that passed through the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last, 2))
    else $error("result appeared without an end-of-text transaction");

endmodule

bind case_insensitive_substring_match csm_checker u_csm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_is_last   (in_ch.is_last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_contains (out_ch.contains)
);
